/* hw/rtl/pgb_pkg.sv */
// shared types and constants for the particle grid binning block
package pgb_pkg;

	localparam int N_W        = 11;
	localparam int SLAB_W     = 10;
	localparam int FACTOR_W   = 32;
	localparam int POS_W      = 32;
	localparam int RADDR_W    = 18;
	localparam int CNT_OUT_W  = 24;
	localparam int CONTRAST_W = 57;
	localparam int STATUS_W   = 2;
	localparam int LIN_W      = 34;
	localparam int ADDR_MAX_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_N0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_N1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_N2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 3'd5;

	localparam logic [N_W-1:0]      RST_GRID_N     = 11'd64;
	localparam logic [SLAB_W-1:0]   RST_SLAB_START = 10'd0;
	localparam logic [N_W-1:0]      RST_SLAB_COUNT = 11'd64;
	localparam logic [FACTOR_W-1:0] RST_FACTOR     = 32'd65536;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [63:0] ONE_Q16      = 64'd65536;
	localparam logic [63:0] SAT_LIMIT    = 64'h0100_0000_0000_FFFF;
	localparam logic [CONTRAST_W-1:0] CONTRAST_MAX = 57'h0FF_FFFF_FFFF_FFFF;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_BEYOND  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_READ,
		OP_REPORT
	} op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [N_W-1:0]      n0;
		logic [N_W-1:0]      n1;
		logic [N_W-1:0]      n2;
		logic [SLAB_W-1:0]   slab_start;
		logic [N_W-1:0]      slab_count;
		logic [FACTOR_W-1:0] factor;
	} cfg_t;

	typedef struct packed {
		op_t                   op;
		status_t               status;
		logic [ADDR_MAX_W-1:0] addr;
	} job_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;

endpackage

/* hw/rtl/pgb_front.sv */
// front end: cell index, slab check and linear address, one job per accepted transaction
module pgb_front #(
	parameter int LOCAL_CELLS   = 262144,
	parameter int POSITION_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          cmd,
	input  logic [pgb_pkg::POS_W-1:0]     pos_x,
	input  logic [pgb_pkg::POS_W-1:0]     pos_y,
	input  logic [pgb_pkg::POS_W-1:0]     pos_z,
	input  logic [pgb_pkg::RADDR_W-1:0]   read_address,
	input  pgb_pkg::cfg_t                 cfg,
	output logic                          push,
	output pgb_pkg::job_t                 job
);

	localparam int NW = pgb_pkg::N_W;
	localparam int PW = POSITION_BITS + NW;
	localparam int LW = pgb_pkg::LIN_W;

	logic                          valid_s1;
	logic                          cmd_s1;
	logic [pgb_pkg::RADDR_W-1:0]   raddr_s1;
	logic [PW-1:0]                 px_s1;
	logic [PW-1:0]                 py_s1;
	logic [PW-1:0]                 pz_s1;
	logic [2*NW-1:0]               nn_s1;

	logic                          valid_s2;
	logic                          cmd_s2;
	logic [pgb_pkg::RADDR_W-1:0]   raddr_s2;
	logic                          in_slab_s2;
	logic [3*NW-1:0]               hi_s2;
	logic [2*NW-1:0]               mid_s2;
	logic [NW-1:0]                 c_s2;

	logic [NW-1:0] a_cell;
	logic [NW-1:0] b_cell;
	logic [NW-1:0] c_cell;
	logic [NW:0]   slab_end;
	logic          in_slab;
	logic [NW-1:0] da;
	logic [LW-1:0] lin;
	logic [LW-1:0] sel;
	logic          fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= cmd;
		raddr_s1 <= read_address;
		px_s1    <= PW'(pos_x[POSITION_BITS-1:0]) * PW'(cfg.n0);
		py_s1    <= PW'(pos_y[POSITION_BITS-1:0]) * PW'(cfg.n1);
		pz_s1    <= PW'(pos_z[POSITION_BITS-1:0]) * PW'(cfg.n2);
		nn_s1    <= (2*NW)'(cfg.n1) * (2*NW)'(cfg.n2);
	end

	always_comb begin
		a_cell   = px_s1[POSITION_BITS +: NW];
		b_cell   = py_s1[POSITION_BITS +: NW];
		c_cell   = pz_s1[POSITION_BITS +: NW];
		slab_end = (NW+1)'(cfg.slab_start) + (NW+1)'(cfg.slab_count);
		in_slab  = (a_cell >= NW'(cfg.slab_start)) && ((NW+1)'(a_cell) < slab_end);
		da       = a_cell - NW'(cfg.slab_start);
	end

	always_ff @(posedge clk) begin
		cmd_s2     <= cmd_s1;
		raddr_s2   <= raddr_s1;
		in_slab_s2 <= in_slab;
		hi_s2      <= (3*NW)'(da) * (3*NW)'(nn_s1);
		mid_s2     <= (2*NW)'(b_cell) * (2*NW)'(cfg.n2);
		c_s2       <= c_cell;
	end

	always_comb begin
		lin  = LW'(hi_s2) + LW'(mid_s2) + LW'(c_s2);
		sel  = (cmd_s2 == pgb_pkg::CMD_READ) ? LW'(raddr_s2) : lin;
		fits = sel < LW'(LOCAL_CELLS);
		push = valid_s2;
		job.addr   = sel[pgb_pkg::ADDR_MAX_W-1:0];
		job.op     = pgb_pkg::OP_REPORT;
		job.status = pgb_pkg::ST_DONE;
		if (cmd_s2 == pgb_pkg::CMD_INSERT && !in_slab_s2) begin
			job.status = pgb_pkg::ST_OUTSIDE;
		end else if (!fits) begin
			job.status = pgb_pkg::ST_BEYOND;
		end else if (cmd_s2 == pgb_pkg::CMD_READ) begin
			job.op = pgb_pkg::OP_READ;
		end else begin
			job.op = pgb_pkg::OP_INSERT;
		end
	end

endmodule

/* hw/rtl/pgb_queue.sv */
// small job queue between the front end and the back end
module pgb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pgb_pkg::job_t push_job,
	input  logic          pop,
	output logic          empty,
	output pgb_pkg::job_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pgb_pkg::job_t  entry_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  fill_q;

	assign empty = (fill_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

endmodule

/* hw/rtl/pgb_back.sv */
// back end: count memory read-modify-write, contrast and result registers
module pgb_back #(
	parameter int LOCAL_CELLS = 262144,
	parameter int COUNT_BITS  = 24,
	parameter int AW          = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  pgb_pkg::job_t                     head,
	input  logic [pgb_pkg::FACTOR_W-1:0]      factor,
	output pgb_pkg::back_stat_t               stat,
	output logic                              done,
	output logic [pgb_pkg::STATUS_W-1:0]      status,
	output logic [pgb_pkg::RADDR_W-1:0]       cell_address,
	output logic [pgb_pkg::CNT_OUT_W-1:0]     cell_count,
	output logic signed [pgb_pkg::CONTRAST_W-1:0] contrast
);

	localparam int PRW = COUNT_BITS + pgb_pkg::FACTOR_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] mem [LOCAL_CELLS];

	pgb_pkg::back_state_t state_q;
	pgb_pkg::back_state_t state_d;
	logic [AW-1:0]         clr_q;
	pgb_pkg::job_t         job_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PRW-1:0]        prod_q;

	logic                      done_q;
	pgb_pkg::status_t          status_q;
	logic [pgb_pkg::RADDR_W-1:0]   addr_out_q;
	logic [pgb_pkg::CNT_OUT_W-1:0] count_out_q;
	logic [pgb_pkg::CONTRAST_W-1:0] contrast_q;

	logic                  pop;
	logic                  rd_en;
	logic                  we;
	logic [AW-1:0]         wa;
	logic [COUNT_BITS-1:0] wd;
	logic [COUNT_BITS-1:0] count_next;
	logic [63:0]           prod64;
	logic [63:0]           diff;
	logic [31:0]           count_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgb_pkg::BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == pgb_pkg::BK_OUT);
			if (state_q == pgb_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		rd_en      = 1'b0;
		we         = 1'b0;
		wa         = job_q.addr[AW-1:0];
		count_next = '0;
		unique case (job_q.op)
			pgb_pkg::OP_INSERT: count_next = (rd_q == COUNT_MAX) ? rd_q : rd_q + 1'b1;
			pgb_pkg::OP_READ:   count_next = rd_q;
			default:            count_next = '0;
		endcase
		wd         = count_next;
		unique case (state_q)
			pgb_pkg::BK_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
				if (clr_q == AW'(LOCAL_CELLS - 1)) begin
					state_d = pgb_pkg::BK_IDLE;
				end
			end
			pgb_pkg::BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					rd_en   = (head.op != pgb_pkg::OP_REPORT);
					state_d = pgb_pkg::BK_READ;
				end
			end
			pgb_pkg::BK_READ: begin
				we      = (job_q.op == pgb_pkg::OP_INSERT);
				state_d = pgb_pkg::BK_MUL;
			end
			pgb_pkg::BK_MUL: begin
				state_d = pgb_pkg::BK_OUT;
			end
			pgb_pkg::BK_OUT: begin
				state_d = pgb_pkg::BK_IDLE;
			end
			default: begin
				state_d = pgb_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[head.addr[AW-1:0]];
		end
	end

	always_comb begin
		prod64     = 64'(prod_q);
		diff       = prod64 - pgb_pkg::ONE_Q16;
		count_wide = 32'(count_q);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == pgb_pkg::BK_READ) begin
			count_q <= count_next;
		end
		if (state_q == pgb_pkg::BK_MUL) begin
			prod_q <= PRW'(count_q) * PRW'(factor);
		end
		if (state_q == pgb_pkg::BK_OUT) begin
			status_q <= job_q.status;
			if (job_q.op == pgb_pkg::OP_REPORT) begin
				addr_out_q  <= '0;
				count_out_q <= '0;
				contrast_q  <= '0;
			end else begin
				addr_out_q  <= job_q.addr[pgb_pkg::RADDR_W-1:0];
				count_out_q <= count_wide[pgb_pkg::CNT_OUT_W-1:0];
				contrast_q  <= (prod64 >= pgb_pkg::SAT_LIMIT) ? pgb_pkg::CONTRAST_MAX
					: diff[pgb_pkg::CONTRAST_W-1:0];
			end
		end
	end

	assign stat.clearing = (state_q == pgb_pkg::BK_CLEAR);
	assign stat.pop      = pop;
	assign done          = done_q;
	assign status        = status_q;
	assign cell_address  = addr_out_q;
	assign cell_count    = count_out_q;
	assign contrast      = contrast_q;

endmodule

/* hw/rtl/particle_grid_binning.sv */
// top level of the particle grid binning block: config registers, credit and wiring
//
//   channel   handshake            payload
//   ------    ---------            -------
//   command   start / busy         cmd, pos_x, pos_y, pos_z, read_address
//   config    cfg_write            cfg_index, cfg_data
//   result    done (one cycle)     status, cell_address, cell_count, contrast
//
// the back end takes one job at a time through its read, multiply and output states,
// a read-modify-write sequence on the single-port count memory, before it takes the next
// after reset the count memory is cleared one entry a cycle, all LOCAL_CELLS entries,
// with busy high; config writes are taken throughout
// busy also rises when QUEUE_DEPTH transactions are in flight ahead of the back end
// results are shown for one cycle and the receiver cannot stall them
module particle_grid_binning #(
	parameter int LOCAL_CELLS   = 262144,
	parameter int COUNT_BITS    = 24,
	parameter int POSITION_BITS = 32,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cmd,
	input  logic [pgb_pkg::POS_W-1:0]             pos_x,
	input  logic [pgb_pkg::POS_W-1:0]             pos_y,
	input  logic [pgb_pkg::POS_W-1:0]             pos_z,
	input  logic [pgb_pkg::RADDR_W-1:0]           read_address,
	input  logic                                  cfg_write,
	input  logic [pgb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pgb_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  done,
	output logic [pgb_pkg::STATUS_W-1:0]          status,
	output logic [pgb_pkg::RADDR_W-1:0]           cell_address,
	output logic [pgb_pkg::CNT_OUT_W-1:0]         cell_count,
	output logic signed [pgb_pkg::CONTRAST_W-1:0] contrast
);

	localparam int AW = $clog2(LOCAL_CELLS);
	localparam int IW = $clog2(QUEUE_DEPTH + 1);

	pgb_pkg::cfg_t       cfg_q;
	logic [IW-1:0]       inflight_q;
	logic                accept;
	logic                push;
	pgb_pkg::job_t       push_job;
	logic                empty;
	pgb_pkg::job_t       head;
	pgb_pkg::back_stat_t stat;

	assign busy   = stat.clearing || (inflight_q == IW'(QUEUE_DEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n0         <= pgb_pkg::RST_GRID_N;
			cfg_q.n1         <= pgb_pkg::RST_GRID_N;
			cfg_q.n2         <= pgb_pkg::RST_GRID_N;
			cfg_q.slab_start <= pgb_pkg::RST_SLAB_START;
			cfg_q.slab_count <= pgb_pkg::RST_SLAB_COUNT;
			cfg_q.factor     <= pgb_pkg::RST_FACTOR;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pgb_pkg::CFG_GRID_N0:    cfg_q.n0 <= cfg_data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_GRID_N1:    cfg_q.n1 <= cfg_data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_GRID_N2:    cfg_q.n2 <= cfg_data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_SLAB_START: cfg_q.slab_start <= cfg_data[pgb_pkg::SLAB_W-1:0];
				pgb_pkg::CFG_SLAB_COUNT: cfg_q.slab_count <= cfg_data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_FACTOR:     cfg_q.factor <= cfg_data[pgb_pkg::FACTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (accept && !stat.pop) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (stat.pop && !accept) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	pgb_front #(
		.LOCAL_CELLS   (LOCAL_CELLS),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.read_address (read_address),
		.cfg          (cfg_q),
		.push         (push),
		.job          (push_job)
	);

	pgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (stat.pop),
		.empty    (empty),
		.head     (head)
	);

	pgb_back #(
		.LOCAL_CELLS (LOCAL_CELLS),
		.COUNT_BITS  (COUNT_BITS),
		.AW          (AW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.factor       (cfg_q.factor),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.cell_address (cell_address),
		.cell_count   (cell_count),
		.contrast     (contrast)
	);

endmodule

/* bench/particle_grid_binning_tb.sv */
// self-checking testbench for the particle grid binning block
module particle_grid_binning_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS       = 262144;
	localparam int CNT_BITS    = 24;
	localparam int PHASES      = 7;
	localparam int RAND_ITEMS  = 215;
	localparam int DRAIN_WAIT  = 8;
	localparam int END_WAIT    = 32;
	localparam int CYCLE_LIMIT = 2000000;

	localparam logic [pgb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct {
		pgb_pkg::status_t                      status;
		logic [pgb_pkg::RADDR_W-1:0]           addr;
		logic [pgb_pkg::CNT_OUT_W-1:0]         count;
		logic [pgb_pkg::CONTRAST_W-1:0]        contrast;
	} cell_result_t;

	class bin_tracker;
		bit [CNT_BITS-1:0]                 cell_cnt [CELLS];
		cell_result_t                      pending_cells [$];
		logic [pgb_pkg::RADDR_W-1:0]       touched [$];
		logic [pgb_pkg::N_W-1:0]           n0, n1, n2, slab_count;
		logic [pgb_pkg::SLAB_W-1:0]        slab_start;
		logic [pgb_pkg::FACTOR_W-1:0]      factor;
		int failures, n_counted, n_outside, n_beyond, n_reads;

		function new();
			n0 = pgb_pkg::RST_GRID_N;
			n1 = pgb_pkg::RST_GRID_N;
			n2 = pgb_pkg::RST_GRID_N;
			slab_start = pgb_pkg::RST_SLAB_START;
			slab_count = pgb_pkg::RST_SLAB_COUNT;
			factor = pgb_pkg::RST_FACTOR;
		endfunction

		function void set_reg(logic [pgb_pkg::CFG_IDX_W-1:0] idx,
				logic [pgb_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				pgb_pkg::CFG_GRID_N0:    n0 = data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_GRID_N1:    n1 = data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_GRID_N2:    n2 = data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_SLAB_START: slab_start = data[pgb_pkg::SLAB_W-1:0];
				pgb_pkg::CFG_SLAB_COUNT: slab_count = data[pgb_pkg::N_W-1:0];
				pgb_pkg::CFG_FACTOR:     factor = data;
				default: ;
			endcase
		endfunction

		function logic [pgb_pkg::CONTRAST_W-1:0] contrast_for(
				logic [pgb_pkg::CNT_OUT_W-1:0] cnt);
			logic [63:0] prod;
			prod = 64'(cnt) * 64'(factor);
			if (prod >= 64'(pgb_pkg::CONTRAST_MAX) + pgb_pkg::ONE_Q16)
				return pgb_pkg::CONTRAST_MAX;
			return pgb_pkg::CONTRAST_W'(prod - pgb_pkg::ONE_Q16);
		endfunction

		function int pending();
			return pending_cells.size();
		endfunction

		function void note_item(logic c, logic [pgb_pkg::POS_W-1:0] x,
				logic [pgb_pkg::POS_W-1:0] y, logic [pgb_pkg::POS_W-1:0] z,
				logic [pgb_pkg::RADDR_W-1:0] ra);
			cell_result_t e;
			logic [63:0] a, b, cz, lin;
			e.status = pgb_pkg::ST_DONE;
			e.addr = '0;
			e.count = '0;
			e.contrast = '0;
			if (c == pgb_pkg::CMD_READ) begin
				n_reads++;
				e.addr = ra;
				e.count = cell_cnt[ra];
				e.contrast = contrast_for(e.count);
			end else begin
				a = (64'(x) * 64'(n0)) >> pgb_pkg::POS_W;
				b = (64'(y) * 64'(n1)) >> pgb_pkg::POS_W;
				cz = (64'(z) * 64'(n2)) >> pgb_pkg::POS_W;
				lin = (a - 64'(slab_start)) * 64'(n1) * 64'(n2) + b * 64'(n2) + cz;
				if (a < 64'(slab_start) || a >= 64'(slab_start) + 64'(slab_count)) begin
					e.status = pgb_pkg::ST_OUTSIDE;
					n_outside++;
				end else if (lin >= 64'(CELLS)) begin
					e.status = pgb_pkg::ST_BEYOND;
					n_beyond++;
				end else begin
					n_counted++;
					if (cell_cnt[lin] != {CNT_BITS{1'b1}})
						cell_cnt[lin] = cell_cnt[lin] + 1'b1;
					e.addr = pgb_pkg::RADDR_W'(lin);
					e.count = cell_cnt[lin];
					e.contrast = contrast_for(e.count);
					touched.push_back(e.addr);
					if (touched.size() > 64)
						void'(touched.pop_front());
				end
			end
			pending_cells.push_back(e);
		endfunction

		function void check_result(logic [pgb_pkg::STATUS_W-1:0] st,
				logic [pgb_pkg::RADDR_W-1:0] ad, logic [pgb_pkg::CNT_OUT_W-1:0] ct,
				logic [pgb_pkg::CONTRAST_W-1:0] cs);
			cell_result_t e;
			if (pending_cells.size() == 0) begin
				$error("result with no transaction outstanding");
				failures++;
				return;
			end
			e = pending_cells.pop_front();
			if (st !== pgb_pkg::STATUS_W'(e.status)) begin
				$error("status expected %0d got %0d", e.status, st);
				failures++;
			end
			if (ad !== e.addr) begin
				$error("cell_address expected %0h got %0h", e.addr, ad);
				failures++;
			end
			if (ct !== e.count) begin
				$error("cell_count expected %0h got %0h", e.count, ct);
				failures++;
			end
			if (cs !== e.contrast) begin
				$error("contrast expected %0h got %0h", e.contrast, cs);
				failures++;
			end
		endfunction
	endclass

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  start;
	logic                                  busy;
	logic                                  cmd;
	logic [pgb_pkg::POS_W-1:0]             pos_x, pos_y, pos_z;
	logic [pgb_pkg::RADDR_W-1:0]           read_address;
	logic                                  cfg_write;
	logic [pgb_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [pgb_pkg::CFG_DATA_W-1:0]        cfg_data;
	logic                                  done;
	logic [pgb_pkg::STATUS_W-1:0]          status;
	logic [pgb_pkg::RADDR_W-1:0]           cell_address;
	logic [pgb_pkg::CNT_OUT_W-1:0]         cell_count;
	logic signed [pgb_pkg::CONTRAST_W-1:0] contrast;

	bin_tracker sb;
	int cycles = 0;

	// n0, n1, n2, slab_start, slab_count, factor per phase
	logic [pgb_pkg::CFG_DATA_W-1:0] settings [PHASES][6] = '{
		'{32'd64, 32'd64, 32'd64, 32'd0, 32'd64, 32'h0001_0000},
		'{32'd16, 32'd16, 32'd16, 32'd4, 32'd8, 32'h0001_8000},
		'{32'd1024, 32'd1024, 32'd1024, 32'd1023, 32'd1, 32'hFFFF_FFFF},
		'{32'd1, 32'd1, 32'd1, 32'd0, 32'd1024, 32'h0000_0000},
		'{32'hFFFF_F800, 32'h0000_0805, 32'hFFFF_F800, 32'hFFFF_FC00, 32'h1234_0003,
			32'h0000_0001},
		'{32'd100, 32'd50, 32'd37, 32'd20, 32'd30, 32'h00A0_0000},
		'{32'd512, 32'd512, 32'd512, 32'd100, 32'd50, 32'h0000_4000}
	};

	particle_grid_binning u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.read_address (read_address),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.status       (status),
		.cell_address (cell_address),
		.cell_count   (cell_count),
		.contrast     (contrast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[particle_grid_binning] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_result(status, cell_address, cell_count, contrast);
	end

	function automatic logic [pgb_pkg::POS_W-1:0] pos_in_cell(logic [63:0] target,
			logic [pgb_pkg::N_W-1:0] n);
		logic [63:0] lo, hi;
		if (n == 0 || target >= 64'(n))
			return $urandom;
		lo = ((target << pgb_pkg::POS_W) + 64'(n) - 1) / 64'(n);
		hi = (((target + 1) << pgb_pkg::POS_W) + 64'(n) - 1) / 64'(n) - 1;
		return pgb_pkg::POS_W'(lo + 64'($urandom_range(0, 32'(hi - lo))));
	endfunction

	function automatic void pick_item(output logic c, output logic [pgb_pkg::POS_W-1:0] x,
			output logic [pgb_pkg::POS_W-1:0] y, output logic [pgb_pkg::POS_W-1:0] z,
			output logic [pgb_pkg::RADDR_W-1:0] ra);
		int sel, span;
		logic [63:0] tx, ty, tz;
		sel = $urandom_range(0, 99);
		c = pgb_pkg::CMD_INSERT;
		x = $urandom;
		y = $urandom;
		z = $urandom;
		ra = pgb_pkg::RADDR_W'($urandom);
		if (sel < 25) begin
			c = pgb_pkg::CMD_READ;
			if (sb.touched.size() != 0 && $urandom_range(0, 1) == 1)
				ra = sb.touched[$urandom_range(0, sb.touched.size() - 1)];
		end else if (sel < 85) begin
			span = (sb.slab_count == 0) ? 0 : int'(sb.slab_count) - 1;
			tx = 64'(sb.slab_start) + 64'($urandom_range(0, span));
			ty = ($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 3))
				: 64'($urandom_range(0, 1023));
			tz = ($urandom_range(0, 1) == 1) ? 64'($urandom_range(0, 3))
				: 64'($urandom_range(0, 1023));
			x = pos_in_cell(tx, sb.n0);
			y = pos_in_cell(ty, sb.n1);
			z = pos_in_cell(tz, sb.n2);
		end
	endfunction

	task automatic send(logic c, logic [pgb_pkg::POS_W-1:0] x, logic [pgb_pkg::POS_W-1:0] y,
			logic [pgb_pkg::POS_W-1:0] z, logic [pgb_pkg::RADDR_W-1:0] ra);
		start <= 1'b1;
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		read_address <= ra;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(c, x, y, z, ra);
	endtask

	task automatic idle_gap(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < pct);
		end
	endtask

	task automatic write_reg(logic [pgb_pkg::CFG_IDX_W-1:0] idx,
			logic [pgb_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	initial begin
		int pct, sent;
		logic c;
		logic [pgb_pkg::POS_W-1:0] x, y, z;
		logic [pgb_pkg::RADDR_W-1:0] ra;
		int idle_pct [4];

		idle_pct = '{0, 79, 0, 33};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = pgb_pkg::CMD_INSERT;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		read_address = '0;
		cfg_write = 1'b0;
		cfg_index = pgb_pkg::CFG_GRID_N0;
		cfg_data = '0;
		sb = new();
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			pct = idle_pct[ph % 4];
			write_reg(pgb_pkg::CFG_GRID_N0, settings[ph][0]);
			write_reg(pgb_pkg::CFG_GRID_N1, settings[ph][1]);
			write_reg(pgb_pkg::CFG_GRID_N2, settings[ph][2]);
			write_reg(pgb_pkg::CFG_SLAB_START, settings[ph][3]);
			write_reg(pgb_pkg::CFG_SLAB_COUNT, settings[ph][4]);
			write_reg(pgb_pkg::CFG_FACTOR, settings[ph][5]);
			if (ph == 4)
				write_reg(CFG_SPARE, 32'hFFFF_FFFF);
			cfg_write <= 1'b0;

			// corner positions under every setting
			send(pgb_pkg::CMD_INSERT, '0, '0, '0, '0);
			send(pgb_pkg::CMD_INSERT, '1, '1, '1, '1);
			if (ph == 0) begin
				send(pgb_pkg::CMD_INSERT, '0, '0, '0, '0);
				send(pgb_pkg::CMD_INSERT, '1, '0, '0, 18'h2AAAA);
				send(pgb_pkg::CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
					18'h15555);
				send(pgb_pkg::CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
					18'h2AAAA);
				send(pgb_pkg::CMD_READ, '1, '1, '1, '0);
				send(pgb_pkg::CMD_READ, '0, '0, '0, '1);
				send(pgb_pkg::CMD_READ, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
					18'h2AAAA);
				send(pgb_pkg::CMD_READ, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
					18'h15555);
			end

			for (int i = 0; i < RAND_ITEMS; i++) begin
				idle_gap(pct);
				pick_item(c, x, y, z, ra);
				send(c, x, y, z, ra);
				sent++;
			end
			start <= 1'b0;
			while (sb.pending() != 0)
				@(posedge clk);
			repeat (DRAIN_WAIT) @(posedge clk);
		end

		repeat (END_WAIT) @(posedge clk);
		$display("covered %0d register settings, %0d random and the directed transactions",
			PHASES, sent);
		$display("inserts counted %0d, outside slab %0d, beyond store %0d, cell reads %0d",
			sb.n_counted, sb.n_outside, sb.n_beyond, sb.n_reads);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("[particle_grid_binning] OK");
		else
			$display("[particle_grid_binning] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/pgb_pkg.sv
hw/rtl/pgb_front.sv
hw/rtl/pgb_queue.sv
hw/rtl/pgb_back.sv
hw/rtl/particle_grid_binning.sv
bench/particle_grid_binning_tb.sv
